// ===== design/aarm_pkg.sv =====
package aarm_pkg;

   // Number of Taylor terms after the first one, per series
   localparam int SERIES_STEPS = 8;

   // pi/2 in Q30
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // 1.0 in Q30
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // Quadrant taken from the two top angle bits
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } aarm_quad_type;

   // Payload carried through the sine/cosine series stages
   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      aarm_quad_type      quad;
      logic [31:0]        x2;
      logic [31:0]        ts;
      logic [31:0]        tc;
      logic signed [33:0] ss;
      logic signed [33:0] cs;
   } aarm_series_type;

endpackage

// ===== design/aarm_term.sv =====
module aarm_term import aarm_pkg::*; #(
   parameter int K = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  aarm_series_type in_data,
   output logic            out_valid,
   output aarm_series_type out_data
);

   // Factorial factors of the next sine and cosine term
   localparam logic [8:0]  DS = 9'(2 * K * (2 * K + 1));
   localparam logic [8:0]  DC = 9'((2 * K - 1) * (2 * K));
   // Floor reciprocals in Q32; quotient estimate is low by at most one
   localparam logic [31:0] RS = 32'(64'h1_0000_0000 / 64'(DS));
   localparam logic [31:0] RC = 32'(64'h1_0000_0000 / 64'(DC));

   logic            v1_ff, v2_ff, v3_ff;
   aarm_series_type d1_ff, d2_ff, d3_ff;
   logic [31:0]     ps_ff, pc_ff, ps2_ff, pc2_ff, qs_ff, qc_ff;
   logic [31:0]     ps_in, pc_in, qs_in, qc_in, tsn, tcn;
   logic [32:0]     rems, remc;
   aarm_series_type d3_in;

   // Stage 1: multiply previous term by x squared
   assign ps_in = 32'((64'(in_data.ts) * 64'(in_data.x2)) >> 30);
   assign pc_in = 32'((64'(in_data.tc) * 64'(in_data.x2)) >> 30);

   // Stage 2: quotient estimate by reciprocal
   assign qs_in = 32'((64'(ps_ff) * 64'(RS)) >> 32);
   assign qc_in = 32'((64'(pc_ff) * 64'(RC)) >> 32);

   // Stage 3: correct the quotient and accumulate
   always_comb begin
      rems = {1'b0, ps2_ff} - 33'(qs_ff) * 33'(DS);
      remc = {1'b0, pc2_ff} - 33'(qc_ff) * 33'(DC);
      tsn = qs_ff + 32'(rems >= 33'(DS));
      tcn = qc_ff + 32'(remc >= 33'(DC));
      d3_in = d2_ff;
      d3_in.ts = tsn;
      d3_in.tc = tcn;
      if (K % 2 == 1) begin
         d3_in.ss = d2_ff.ss - 34'(signed'({1'b0, tsn}));
         d3_in.cs = d2_ff.cs - 34'(signed'({1'b0, tcn}));
      end else begin
         d3_in.ss = d2_ff.ss + 34'(signed'({1'b0, tsn}));
         d3_in.cs = d2_ff.cs + 34'(signed'({1'b0, tcn}));
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      d1_ff  <= in_data;
      ps_ff  <= ps_in;
      pc_ff  <= pc_in;
      d2_ff  <= d1_ff;
      ps2_ff <= ps_ff;
      pc2_ff <= pc_ff;
      qs_ff  <= qs_in;
      qc_ff  <= qc_in;
      d3_ff  <= d3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

// ===== design/axis_angle_rotation_matrix_core.sv =====
// A taken start reaches rsp_valid through setup, Taylor and output register stages.
// Throughput: one transaction per cycle; busy is always low, the pipeline never stalls.
// Latency is set by the eight Taylor steps (three stages each) plus setup and entry math.
// Reset clears all valid bits; no result appears in the cycle after reset.
module axis_angle_rotation_matrix_core import aarm_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [15:0]     req_axis_x,
   input  logic signed [15:0]     req_axis_y,
   input  logic signed [15:0]     req_axis_z,
   input  logic [ANGLE_BITS-1:0]  req_angle,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_row1_col1,
   output logic signed [15:0]     rsp_row1_col2,
   output logic signed [15:0]     rsp_row1_col3,
   output logic signed [15:0]     rsp_row2_col1,
   output logic signed [15:0]     rsp_row2_col2,
   output logic signed [15:0]     rsp_row2_col3,
   output logic signed [15:0]     rsp_row3_col1,
   output logic signed [15:0]     rsp_row3_col2,
   output logic signed [15:0]     rsp_row3_col3
);

   localparam int F   = FRAC_BITS;
   localparam int SH  = 30 - F;
   localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;
   localparam int RF  = 1 << (F - 1);
   localparam int MW  = F + 35;
   localparam int AW  = F + 36;
   localparam int SW  = F + 18;
   localparam int CW  = 2 * F + 2;
   localparam int LAT = 31;
   localparam logic signed [F+2:0] ONE_A = (F + 3)'(1) << F;

   // Clamp a Q30 sum to [0, 1] and round half up to F fraction bits
   function automatic logic [F:0] clamp_round(input logic signed [33:0] v);
      logic [30:0] c;
      logic [31:0] r;
      if (v < 0) c = '0;
      else if (v > 34'sd1073741824) c = 31'h4000_0000;
      else c = v[30:0];
      r = (32'(c) + 32'(RND)) >> SH;
      return r[F:0];
   endfunction

   // Round product, add term, round again, saturate to 16 bits
   function automatic logic signed [15:0] entry_f(input logic signed [MW-1:0] m,
                                                 input logic signed [AW-1:0] add);
      logic signed [AW-1:0] t;
      logic signed [AW-1:0] r;
      t = (AW'(m) + AW'(RF)) >>> F;
      r = (t + add + AW'(RF)) >>> F;
      if (r > AW'(32767)) return 16'sh7fff;
      else if (r < -AW'(32768)) return -16'sh8000;
      else return r[15:0];
   endfunction

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 0: capture transaction
   logic                    v0_ff;
   logic signed [15:0]      x0_ff, y0_ff, z0_ff;
   aarm_quad_type           q0_ff;
   logic [29:0]             frac0_ff, frac0_in;
   assign frac0_in = 30'(req_angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);

   // Stage 1: scale turn fraction to radians
   logic                    v1_ff;
   logic signed [15:0]      x1_ff, y1_ff, z1_ff;
   aarm_quad_type           q1_ff;
   logic [30:0]             xr1_ff, xr1_in;
   assign xr1_in = 31'((64'(frac0_ff) * 64'(HALF_PI_Q30)) >> 30);

   // Stage 2: x squared and series seed
   aarm_series_type         series [SERIES_STEPS+1];
   logic                    sv [SERIES_STEPS+1];
   logic                    v2_ff;
   aarm_series_type         s2_ff, s2_in;
   always_comb begin
      s2_in.ax   = x1_ff;
      s2_in.ay   = y1_ff;
      s2_in.az   = z1_ff;
      s2_in.quad = q1_ff;
      s2_in.x2   = 32'((64'(xr1_ff) * 64'(xr1_ff)) >> 30);
      s2_in.ts   = 32'(xr1_ff);
      s2_in.tc   = ONE_Q30;
      s2_in.ss   = 34'(signed'({1'b0, xr1_ff}));
      s2_in.cs   = 34'(signed'({1'b0, ONE_Q30}));
   end
   assign series[0] = s2_ff;
   assign sv[0]     = v2_ff;

   // Taylor steps
   for (genvar k = 0; k < SERIES_STEPS; k++) begin : g_term
      aarm_term #(.K(k + 1)) u_term (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sv[k]),
         .in_data   (series[k]),
         .out_valid (sv[k+1]),
         .out_data  (series[k+1])
      );
   end

   // F1: clamp, round, quadrant map, a = 1 - cos
   aarm_series_type         sl;
   logic [F:0]              sb, cb;
   logic signed [F+1:0]     sbe, cbe, s_in, c_in;
   logic                    vf1_ff;
   logic signed [15:0]      xf1_ff, yf1_ff, zf1_ff;
   logic signed [F+1:0]     s_ff, c_ff;
   logic signed [F+2:0]     a_ff, a_in;
   always_comb begin
      sl  = series[SERIES_STEPS];
      sb  = clamp_round(sl.ss);
      cb  = clamp_round(sl.cs);
      sbe = signed'({1'b0, sb});
      cbe = signed'({1'b0, cb});
      case (sl.quad)
         QUAD_0: begin s_in = sbe;  c_in = cbe;  end
         QUAD_1: begin s_in = cbe;  c_in = -sbe; end
         QUAD_2: begin s_in = -sbe; c_in = -cbe; end
         default: begin s_in = -cbe; c_in = sbe; end
      endcase
      a_in = ONE_A - (F + 3)'(c_in);
   end

   // F2: axis products and sine terms
   logic                    vf2_ff;
   logic signed [31:0]      pxx_ff, pxy_ff, pxz_ff, pyy_ff, pyz_ff, pzz_ff;
   logic signed [SW-1:0]    xs_ff, ys_ff, zs_ff;
   logic signed [CW-1:0]    cq_ff;
   logic signed [F+2:0]     a2_ff;

   // F3: products times a
   logic                    vf3_ff;
   logic signed [MW-1:0]    mxx_ff, mxy_ff, mxz_ff, myy_ff, myz_ff, mzz_ff;
   logic signed [SW-1:0]    xs3_ff, ys3_ff, zs3_ff;
   logic signed [CW-1:0]    cq3_ff;

   // F4: output register
   logic                    vo_ff;
   logic signed [15:0]      o11_ff, o12_ff, o13_ff, o21_ff, o22_ff, o23_ff;
   logic signed [15:0]      o31_ff, o32_ff, o33_ff;

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         vf1_ff <= 1'b0;
         vf2_ff <= 1'b0;
         vf3_ff <= 1'b0;
         vo_ff  <= 1'b0;
      end else begin
         v0_ff  <= accept;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         vf1_ff <= sv[SERIES_STEPS];
         vf2_ff <= vf1_ff;
         vf3_ff <= vf2_ff;
         vo_ff  <= vf3_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x0_ff    <= req_axis_x;
      y0_ff    <= req_axis_y;
      z0_ff    <= req_axis_z;
      q0_ff    <= aarm_quad_type'(req_angle[ANGLE_BITS-1:ANGLE_BITS-2]);
      frac0_ff <= frac0_in;

      x1_ff  <= x0_ff;
      y1_ff  <= y0_ff;
      z1_ff  <= z0_ff;
      q1_ff  <= q0_ff;
      xr1_ff <= xr1_in;

      s2_ff <= s2_in;

      xf1_ff <= sl.ax;
      yf1_ff <= sl.ay;
      zf1_ff <= sl.az;
      s_ff   <= s_in;
      c_ff   <= c_in;
      a_ff   <= a_in;

      pxx_ff <= xf1_ff * xf1_ff;
      pxy_ff <= xf1_ff * yf1_ff;
      pxz_ff <= xf1_ff * zf1_ff;
      pyy_ff <= yf1_ff * yf1_ff;
      pyz_ff <= yf1_ff * zf1_ff;
      pzz_ff <= zf1_ff * zf1_ff;
      xs_ff  <= xf1_ff * s_ff;
      ys_ff  <= yf1_ff * s_ff;
      zs_ff  <= zf1_ff * s_ff;
      cq_ff  <= CW'(c_ff) <<< F;
      a2_ff  <= a_ff;

      mxx_ff <= pxx_ff * a2_ff;
      mxy_ff <= pxy_ff * a2_ff;
      mxz_ff <= pxz_ff * a2_ff;
      myy_ff <= pyy_ff * a2_ff;
      myz_ff <= pyz_ff * a2_ff;
      mzz_ff <= pzz_ff * a2_ff;
      xs3_ff <= xs_ff;
      ys3_ff <= ys_ff;
      zs3_ff <= zs_ff;
      cq3_ff <= cq_ff;

      o11_ff <= entry_f(mxx_ff, AW'(cq3_ff));
      o12_ff <= entry_f(mxy_ff, AW'(zs3_ff));
      o13_ff <= entry_f(mxz_ff, -AW'(ys3_ff));
      o21_ff <= entry_f(mxy_ff, -AW'(zs3_ff));
      o22_ff <= entry_f(myy_ff, AW'(cq3_ff));
      o23_ff <= entry_f(myz_ff, AW'(xs3_ff));
      o31_ff <= entry_f(mxz_ff, AW'(ys3_ff));
      o32_ff <= entry_f(myz_ff, -AW'(xs3_ff));
      o33_ff <= entry_f(mzz_ff, AW'(cq3_ff));
   end

   assign rsp_valid     = vo_ff;
   assign rsp_row1_col1 = o11_ff;
   assign rsp_row1_col2 = o12_ff;
   assign rsp_row1_col3 = o13_ff;
   assign rsp_row2_col1 = o21_ff;
   assign rsp_row2_col2 = o22_ff;
   assign rsp_row2_col3 = o23_ff;
   assign rsp_row3_col1 = o31_ff;
   assign rsp_row3_col2 = o32_ff;
   assign rsp_row3_col3 = o33_ff;

   // A result only follows a transaction taken the fixed latency earlier
   a_rsp_src: assert property (@(posedge clock) rsp_valid |-> $past(accept, LAT))
      else $error("result without matching transaction");

   // Reset flushes the pipeline
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

   // A transaction leaving the Taylor steps of a running pipeline reaches rsp_valid
   a_rsp_out: assert property (@(posedge clock) disable iff (reset)
      (sv[SERIES_STEPS] && !$past(reset) && !$past(reset, 2) && !$past(reset, 3)
       && !$past(reset, 4)) |-> ##4 rsp_valid)
      else $error("transaction lost in output stages");

endmodule

// ===== dv/axis_angle_rotation_matrix_core_tb.sv =====
module axis_angle_rotation_matrix_core_tb import aarm_pkg::*;;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int LATENCY    = 31;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic [15:0]        angle;
   } rot_req_type;

   typedef struct {
      logic signed [15:0] m [9];
   } rot_matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_axis_x = '0;
   logic signed [15:0] req_axis_y = '0;
   logic signed [15:0] req_axis_z = '0;
   logic [ANGLE_BITS-1:0] req_angle = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_row1_col1, rsp_row1_col2, rsp_row1_col3;
   logic signed [15:0] rsp_row2_col1, rsp_row2_col2, rsp_row2_col3;
   logic signed [15:0] rsp_row3_col1, rsp_row3_col2, rsp_row3_col3;

   rot_req_type    pending_reqs [$];
   rot_matrix_type expected_matrices [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  gap_left = 0;

   axis_angle_rotation_matrix_core #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) dut (
      .clock, .reset, .start, .busy,
      .req_axis_x, .req_axis_y, .req_axis_z, .req_angle,
      .rsp_valid,
      .rsp_row1_col1, .rsp_row1_col2, .rsp_row1_col3,
      .rsp_row2_col1, .rsp_row2_col2, .rsp_row2_col3,
      .rsp_row3_col1, .rsp_row3_col2, .rsp_row3_col3
   );

   always #5 clock = ~clock;

   // Round half up: floor((v + 2^(sh-1)) / 2^sh)
   function automatic longint round_half_up(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_q30(longint v);
      if (v < 0) v = 0;
      if (v > (longint'(1) << 30)) v = longint'(1) << 30;
      return round_half_up(v, 30 - FRAC_BITS);
   endfunction

   function automatic logic signed [15:0] matrix_entry(longint prod, longint a, longint addend);
      longint r;
      r = round_half_up(round_half_up(prod * a, FRAC_BITS) + addend, FRAC_BITS);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   // Taylor sin/cos in Q30 on the first quadrant, quadrant fold, Rodrigues entries
   function automatic rot_matrix_type rotation_matrix(rot_req_type t);
      rot_matrix_type res;
      aarm_quad_type  quad;
      longint unsigned rem, xr, x2, ts, tc;
      longint ss, cs, sb, cb, s, c, a, cq, x, y, z;
      x = t.ax; y = t.ay; z = t.az;
      quad = aarm_quad_type'(t.angle[ANGLE_BITS-1 -: 2]);
      rem = t.angle[ANGLE_BITS-3:0];
      xr = ((rem << (32 - ANGLE_BITS)) * longint'(HALF_PI_Q30)) >> 30;
      x2 = (xr * xr) >> 30;
      ts = xr; tc = longint'(ONE_Q30);
      ss = xr; cs = longint'(ONE_Q30);
      for (int k = 1; k <= SERIES_STEPS; k++) begin
         ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
         tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
         if (k & 1) begin
            ss -= ts; cs -= tc;
         end else begin
            ss += ts; cs += tc;
         end
      end
      sb = clamp_q30(ss);
      cb = clamp_q30(cs);
      case (quad)
         QUAD_0: begin s = sb;  c = cb;  end
         QUAD_1: begin s = cb;  c = -sb; end
         QUAD_2: begin s = -sb; c = -cb; end
         default: begin s = -cb; c = sb; end
      endcase
      a  = (longint'(1) << FRAC_BITS) - c;
      cq = c << FRAC_BITS;
      res.m[0] = matrix_entry(x * x, a, cq);
      res.m[1] = matrix_entry(x * y, a, z * s);
      res.m[2] = matrix_entry(x * z, a, -(y * s));
      res.m[3] = matrix_entry(y * x, a, -(z * s));
      res.m[4] = matrix_entry(y * y, a, cq);
      res.m[5] = matrix_entry(y * z, a, x * s);
      res.m[6] = matrix_entry(z * x, a, y * s);
      res.m[7] = matrix_entry(z * y, a, -(x * s));
      res.m[8] = matrix_entry(z * z, a, cq);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] rand_comp();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Driver: one transaction per accepted start
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // transaction accepted this edge
         expected_matrices.push_back(rotation_matrix('{req_axis_x, req_axis_y,
                                                       req_axis_z, req_angle}));
         gap_left = pick_gap();
         if (gap_left == 0 && pending_reqs.size() > 0) begin
            rot_req_type t;
            t = pending_reqs.pop_front();
            req_axis_x <= t.ax; req_axis_y <= t.ay; req_axis_z <= t.az;
            req_angle <= t.angle;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            rot_req_type t;
            t = pending_reqs.pop_front();
            req_axis_x <= t.ax; req_axis_y <= t.ay; req_axis_z <= t.az;
            req_angle <= t.angle;
            start <= 1'b1;
         end
      end
   end

   // Monitor: compare each result with the oldest expected matrix
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         logic signed [15:0] got [9];
         rot_matrix_type want;
         got = '{rsp_row1_col1, rsp_row1_col2, rsp_row1_col3,
                 rsp_row2_col1, rsp_row2_col2, rsp_row2_col3,
                 rsp_row3_col1, rsp_row3_col2, rsp_row3_col3};
         if (expected_matrices.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            want = expected_matrices.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (got[i] !== want.m[i]) begin
                  $error("row%0d_col%0d: expected %0d, actual %0d",
                         i / 3 + 1, i % 3 + 1, want.m[i], got[i]);
                  fail_count++;
               end
            end
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int quads [4];
      int comps [5];
      quads = '{0, 16384, 32768, 49152};
      comps = '{-16384, 16384, 0, 11585, -11585};
      // Directed: axis extremes, quadrant boundaries, non-unit axes that saturate
      pending_reqs.push_back('{16384, 0, 0, 0});
      pending_reqs.push_back('{0, 16384, 0, 16384});
      pending_reqs.push_back('{0, 0, 16384, 32768});
      pending_reqs.push_back('{-16384, 0, 0, 49152});
      pending_reqs.push_back('{0, -16384, 0, 65535});
      pending_reqs.push_back('{0, 0, -16384, 16383});
      pending_reqs.push_back('{16384, 16384, 16384, 32768});
      pending_reqs.push_back('{-16384, -16384, -16384, 32768});
      pending_reqs.push_back('{16384, -16384, 16384, 16384});
      pending_reqs.push_back('{-16384, 16384, -16384, 49152});
      pending_reqs.push_back('{0, 0, 0, 8192});
      pending_reqs.push_back('{9459, 9459, 9459, 21845});
      pending_reqs.push_back('{11585, -11585, 0, 1});
      pending_reqs.push_back('{-11585, 0, 11585, 32767});
      pending_reqs.push_back('{16384, 16384, -16384, 49151});
      pending_reqs.push_back('{16384, 0, 16384, 65535});
      // Random: axes built from listed and random components, some fully random, quadrant-edge angles too
      for (int n = 0; n < 950; n++) begin
         rot_req_type t;
         int r;
         r = $urandom_range(0, 9);
         if (r < 5) begin
            int c;
            c = $urandom_range(0, 2);
            t.ax = 0; t.ay = 0; t.az = 0;
            t.ax = (c == 0) ? comps[$urandom_range(0, 4)] : rand_comp();
            t.ay = (c == 1) ? comps[$urandom_range(0, 4)] : rand_comp();
            t.az = (c == 2) ? comps[$urandom_range(0, 4)] : rand_comp();
         end else if (r < 8) begin
            t.ax = comps[$urandom_range(0, 4)];
            t.ay = comps[$urandom_range(0, 4)];
            t.az = comps[$urandom_range(0, 4)];
         end else begin
            t.ax = rand_comp(); t.ay = rand_comp(); t.az = rand_comp();
         end
         if ($urandom_range(0, 7) == 0)
            t.angle = 16'(quads[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1);
         else
            t.angle = 16'($urandom_range(0, 65535));
         pending_reqs.push_back(t);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !start);
      wait (expected_matrices.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/aarm_pkg.sv
design/aarm_term.sv
design/axis_angle_rotation_matrix_core.sv
dv/axis_angle_rotation_matrix_core_tb.sv
